// ----- rtl/tcce_pkg.sv -----
package tcce_pkg;

  localparam int MAX_COLS_DEF  = 128;
  localparam int MAX_ROWS_DEF  = 64;
  localparam int TAB_WIDTH_DEF = 8;

  localparam int RESULT_LIMIT = 16;
  localparam int CNT_W        = $clog2(RESULT_LIMIT + 1);

  localparam int CODE_W     = 8;
  localparam int COL_OUT_W  = 7;
  localparam int ROW_OUT_W  = 6;
  localparam int COLS_REG_W = 8;
  localparam int ROWS_REG_W = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;
  localparam int OUT_DATA_W = 40;
  localparam int KIND_W     = 2;

  localparam int Q_DEPTH = 2;
  localparam int QP_W    = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int QC_W    = $clog2(Q_DEPTH + 1);

  localparam logic [CODE_W-1:0] SPACE_CODE = 8'h20;
  localparam logic [CODE_W-1:0] CODE_BS    = 8'h08;
  localparam logic [CODE_W-1:0] CODE_TAB   = 8'h09;
  localparam logic [CODE_W-1:0] CODE_NL    = 8'h0A;
  localparam logic [CODE_W-1:0] CODE_CR    = 8'h0D;

  localparam logic [CFG_IDX_W-1:0] REG_COLS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS = 2'd1;

  localparam logic [COLS_REG_W-1:0] COLS_RESET = 8'd80;
  localparam logic [ROWS_REG_W-1:0] ROWS_RESET = 7'd25;

  typedef enum logic [KIND_W-1:0] {
    KIND_CELL   = 2'd0,
    KIND_SCROLL = 2'd1,
    KIND_MOVE   = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    OP_PRINT     = 3'd0,
    OP_NEWLINE   = 3'd1,
    OP_RETURN    = 3'd2,
    OP_TAB       = 3'd3,
    OP_BACKSPACE = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_EXEC   = 2'd1,
    ST_SCROLL = 2'd2,
    ST_BLANK  = 2'd3
  } back_state_t;

  typedef struct packed {
    op_t               op;
    logic [CODE_W-1:0] glyph;
  } q_entry_t;

  typedef struct packed {
    logic     valid;
    q_entry_t entry;
  } q_item_t;

  typedef struct packed {
    kind_t                kind;
    logic [COL_OUT_W-1:0] cell_col;
    logic [ROW_OUT_W-1:0] cell_row;
    logic [CODE_W-1:0]    glyph;
    logic [COL_OUT_W-1:0] cur_col;
    logic [ROW_OUT_W-1:0] cur_row;
    logic                 last;
  } result_t;

endpackage

// ----- rtl/text_console_cursor_engine_core.sv -----
// An input code passes through the queue and the back end's op and glyph registers, and its
// result is held in the output register. A tab writes one space per step; a scroll after a cell
// write adds a scroll step, and every scroll then blanks each column in use of the new row.
// The back end handles one code at a time; a two-entry queue decouples the input side.
// Reset, and a write to either register, start a clearing pass over all
// MAX_ROWS * 2**COL_W store entries (8192 by default) with in_tready low.
module text_console_cursor_engine_core
  import tcce_pkg::*;
#(
  parameter int MAX_COLS  = MAX_COLS_DEF,
  parameter int MAX_ROWS  = MAX_ROWS_DEF,
  parameter int TAB_WIDTH = TAB_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // code_in [7:0]
  input  logic [CODE_W-1:0]     in_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // cell_col [6:0], cell_row [12:7], glyph [20:13], cursor_col_out [27:21],
  // cursor_row_out [33:28], zero fill [39:34]
  output logic [OUT_DATA_W-1:0] out_tdata,
  // kind [1:0]
  output logic [KIND_W-1:0]     out_tuser,
  output logic                  out_tlast,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int COL_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

  logic [COLS_REG_W-1:0] cols_r, cols_nxt;
  logic [ROWS_REG_W-1:0] rows_r, rows_nxt;
  logic                  clear_req;
  logic [COL_W:0]        eff_cols;
  logic [ROW_W:0]        eff_rows;

  q_item_t push;
  q_item_t head;
  logic    q_full;
  logic    pop;
  logic    clear_busy;
  result_t res;

  always_comb begin
    cols_nxt  = cols_r;
    rows_nxt  = rows_r;
    clear_req = 1'b0;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_COLS: begin
          cols_nxt  = cfg_wdata;
          clear_req = 1'b1;
        end
        REG_ROWS: begin
          rows_nxt  = cfg_wdata[ROWS_REG_W-1:0];
          clear_req = 1'b1;
        end
        default: begin
          clear_req = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_r <= COLS_RESET;
      rows_r <= ROWS_RESET;
    end else begin
      cols_r <= cols_nxt;
      rows_r <= rows_nxt;
    end
  end

  always_comb begin
    if (cols_r == '0) begin
      eff_cols = (COL_W + 1)'(1);
    end else if (int'(cols_r) > MAX_COLS) begin
      eff_cols = (COL_W + 1)'(MAX_COLS);
    end else begin
      eff_cols = (COL_W + 1)'(cols_r);
    end
    if (rows_r == '0) begin
      eff_rows = (ROW_W + 1)'(1);
    end else if (int'(rows_r) > MAX_ROWS) begin
      eff_rows = (ROW_W + 1)'(MAX_ROWS);
    end else begin
      eff_rows = (ROW_W + 1)'(rows_r);
    end
  end

  tcce_front u_front (
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .q_full     (q_full),
    .clear_busy (clear_busy),
    .push       (push)
  );

  tcce_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .pop   (pop),
    .full  (q_full),
    .head  (head)
  );

  tcce_back #(
    .MAX_COLS  (MAX_COLS),
    .MAX_ROWS  (MAX_ROWS),
    .TAB_WIDTH (TAB_WIDTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .clear_req  (clear_req),
    .eff_cols   (eff_cols),
    .eff_rows   (eff_rows),
    .head       (head),
    .pop        (pop),
    .clear_busy (clear_busy),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_res    (res)
  );

  assign out_tdata = {6'b0, res.cur_row, res.cur_col, res.glyph, res.cell_row, res.cell_col};
  assign out_tuser = res.kind;
  assign out_tlast = res.last;

endmodule

// ----- rtl/tcce_ram.sv -----
module tcce_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ----- rtl/tcce_front.sv -----
module tcce_front
  import tcce_pkg::*;
(
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [CODE_W-1:0] in_tdata,
  input  logic              q_full,
  input  logic              clear_busy,
  output q_item_t           push
);

  always_comb begin
    push.valid       = in_tvalid && in_tready;
    push.entry.glyph = in_tdata;
    unique case (in_tdata)
      CODE_NL: begin
        push.entry.op = OP_NEWLINE;
      end
      CODE_CR: begin
        push.entry.op = OP_RETURN;
      end
      CODE_TAB: begin
        push.entry.op    = OP_TAB;
        push.entry.glyph = SPACE_CODE;
      end
      CODE_BS: begin
        push.entry.op    = OP_BACKSPACE;
        push.entry.glyph = SPACE_CODE;
      end
      default: begin
        push.entry.op = OP_PRINT;
      end
    endcase
  end

  assign in_tready = !q_full && !clear_busy;

endmodule

// ----- rtl/tcce_queue.sv -----
module tcce_queue
  import tcce_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  q_item_t push,
  input  logic    pop,
  output logic    full,
  output q_item_t head
);

  q_entry_t        slot_r [Q_DEPTH];
  logic [QP_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QP_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QC_W-1:0] count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push.valid) begin
      wr_ptr_nxt = (wr_ptr_r == QP_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QP_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push.valid && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push.valid) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.valid) begin
      slot_r[wr_ptr_r] <= push.entry;
    end
  end

  assign full       = (count_r == QC_W'(Q_DEPTH));
  assign head.valid = (count_r != '0);
  assign head.entry = slot_r[rd_ptr_r];

endmodule

// ----- rtl/tcce_back.sv -----
module tcce_back
  import tcce_pkg::*;
#(
  parameter int MAX_COLS  = MAX_COLS_DEF,
  parameter int MAX_ROWS  = MAX_ROWS_DEF,
  parameter int TAB_WIDTH = TAB_WIDTH_DEF,
  localparam int COL_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1,
  localparam int ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           clear_req,
  input  logic [COL_W:0] eff_cols,
  input  logic [ROW_W:0] eff_rows,
  input  q_item_t        head,
  output logic           pop,
  output logic           clear_busy,
  input  logic           out_tready,
  output logic           out_tvalid,
  output result_t        out_res
);

  localparam int PH_W   = (TAB_WIDTH > 1) ? $clog2(TAB_WIDTH) : 1;
  localparam int TL_W   = $clog2(TAB_WIDTH + 1);
  localparam int AW     = ROW_W + COL_W;
  localparam int DEPTH  = MAX_ROWS << COL_W;
  localparam int RAM_AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  back_state_t       state_r, state_nxt;
  op_t               op_r, op_nxt;
  logic [CODE_W-1:0] glyph_r, glyph_nxt;
  logic [COL_W-1:0]  ccol_r, ccol_nxt;
  logic [ROW_W-1:0]  crow_r, crow_nxt;
  logic [ROW_W-1:0]  top_r, top_nxt;
  logic [PH_W-1:0]   phase_r, phase_nxt;
  logic [TL_W-1:0]   tab_left_r, tab_left_nxt;
  logic [CNT_W-1:0]  res_cnt_r, res_cnt_nxt;
  logic              more_r, more_nxt;
  logic [COL_W-1:0]  blank_col_r, blank_col_nxt;
  logic [ROW_W-1:0]  blank_row_r, blank_row_nxt;
  logic              clr_busy_r, clr_busy_nxt;
  logic [RAM_AW-1:0] clr_addr_r, clr_addr_nxt;
  logic              out_valid_r, out_valid_nxt;
  result_t           out_res_r;
  result_t           res_nxt;
  logic              res_load;

  logic              ram_we;
  logic [RAM_AW-1:0] ram_addr;
  logic [CODE_W-1:0] ram_wdata;
  logic [CODE_W-1:0] ram_rdata;
  logic [ROW_W-1:0]  addr_row;
  logic [COL_W-1:0]  addr_col;
  logic [AW-1:0]     addr_full;
  logic              cell_we;

  logic              wv_q_r, wv_q2_r;
  logic [RAM_AW-1:0] wa_q_r;
  logic [CODE_W-1:0] wd_q_r, wd_q2_r;

  logic [COL_W:0]    ccol_ext;
  logic [ROW_W:0]    crow_ext;
  logic [ROW_W:0]    top_ext;
  logic [ROW_W:0]    phys_sum;
  logic [ROW_W:0]    phys_wrap;
  logic [ROW_W:0]    rows_m1;
  logic [COL_W:0]    blank_ext;
  logic [ROW_W-1:0]  phys;
  logic [ROW_W-1:0]  rows_last;
  logic [ROW_W-1:0]  top_inc;
  logic [PH_W-1:0]   phase_inc;
  logic [PH_W-1:0]   phase_dec;
  logic [COL_W-1:0]  ccol_dec;
  logic [CNT_W-1:0]  res_after;
  logic              wrap;
  logic              bottom;
  logic              scroll;
  logic              more;
  logic              out_free;

  function automatic logic [COL_OUT_W-1:0] col_out(logic [COL_W-1:0] c);
    logic [COL_W+COL_OUT_W-1:0] w;
    w = {{COL_OUT_W{1'b0}}, c};
    return w[COL_OUT_W-1:0];
  endfunction

  function automatic logic [ROW_OUT_W-1:0] row_out(logic [ROW_W-1:0] r);
    logic [ROW_W+ROW_OUT_W-1:0] w;
    w = {{ROW_OUT_W{1'b0}}, r};
    return w[ROW_OUT_W-1:0];
  endfunction

  always_comb begin
    ccol_ext  = {1'b0, ccol_r} + 1'b1;
    crow_ext  = {1'b0, crow_r} + 1'b1;
    top_ext   = {1'b0, top_r} + 1'b1;
    phys_sum  = {1'b0, top_r} + {1'b0, crow_r};
    phys_wrap = phys_sum - eff_rows;
    rows_m1   = eff_rows - 1'b1;
    blank_ext = {1'b0, blank_col_r} + 1'b1;
    wrap      = (ccol_ext >= eff_cols);
    bottom    = (crow_ext >= eff_rows);
    scroll    = wrap && bottom;
    phys      = (phys_sum >= eff_rows) ? phys_wrap[ROW_W-1:0] : phys_sum[ROW_W-1:0];
    rows_last = rows_m1[ROW_W-1:0];
    top_inc   = (top_ext >= eff_rows) ? '0 : top_ext[ROW_W-1:0];
    phase_inc = (phase_r == PH_W'(TAB_WIDTH - 1)) ? '0 : phase_r + 1'b1;
    phase_dec = (phase_r == '0) ? PH_W'(TAB_WIDTH - 1) : phase_r - 1'b1;
    ccol_dec  = ccol_r - 1'b1;
    res_after = res_cnt_r + CNT_W'(1) + CNT_W'(scroll);
    more      = (op_r == OP_TAB) && (tab_left_r > TL_W'(1)) &&
                (res_after <= CNT_W'(RESULT_LIMIT - 2));
    out_free  = !out_valid_r || out_tready;
  end

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    glyph_nxt     = glyph_r;
    ccol_nxt      = ccol_r;
    crow_nxt      = crow_r;
    top_nxt       = top_r;
    phase_nxt     = phase_r;
    tab_left_nxt  = tab_left_r;
    res_cnt_nxt   = res_cnt_r;
    more_nxt      = more_r;
    blank_col_nxt = blank_col_r;
    blank_row_nxt = blank_row_r;
    clr_busy_nxt  = clr_busy_r;
    clr_addr_nxt  = clr_addr_r;
    pop           = 1'b0;
    res_load      = 1'b0;
    res_nxt       = '0;
    cell_we       = 1'b0;
    addr_row      = phys;
    addr_col      = ccol_r;
    ram_wdata     = SPACE_CODE;

    unique case (state_r)
      ST_IDLE: begin
        if (!clr_busy_r && head.valid) begin
          pop          = 1'b1;
          op_nxt       = head.entry.op;
          glyph_nxt    = head.entry.glyph;
          tab_left_nxt = TL_W'(TAB_WIDTH) - TL_W'(phase_r);
          res_cnt_nxt  = '0;
          state_nxt    = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (out_free) begin
          res_load  = 1'b1;
          state_nxt = ST_IDLE;
          unique case (op_r)
            OP_NEWLINE: begin
              ccol_nxt     = '0;
              phase_nxt    = '0;
              res_nxt.last = 1'b1;
              if (bottom) begin
                top_nxt        = top_inc;
                crow_nxt       = rows_last;
                blank_row_nxt  = top_r;
                blank_col_nxt  = '0;
                more_nxt       = 1'b0;
                res_nxt.kind    = KIND_SCROLL;
                res_nxt.cur_row = row_out(rows_last);
                state_nxt      = ST_BLANK;
              end else begin
                crow_nxt        = crow_ext[ROW_W-1:0];
                res_nxt.kind    = KIND_MOVE;
                res_nxt.cur_row = row_out(crow_ext[ROW_W-1:0]);
              end
            end
            OP_RETURN: begin
              ccol_nxt        = '0;
              phase_nxt       = '0;
              res_nxt.kind    = KIND_MOVE;
              res_nxt.cur_row = row_out(crow_r);
              res_nxt.last    = 1'b1;
            end
            OP_BACKSPACE: begin
              res_nxt.last    = 1'b1;
              res_nxt.cur_row = row_out(crow_r);
              if (ccol_r == '0) begin
                res_nxt.kind = KIND_MOVE;
              end else begin
                ccol_nxt         = ccol_dec;
                phase_nxt        = phase_dec;
                cell_we          = 1'b1;
                addr_col         = ccol_dec;
                res_nxt.kind     = KIND_CELL;
                res_nxt.cell_col = col_out(ccol_dec);
                res_nxt.cell_row = row_out(crow_r);
                res_nxt.glyph    = SPACE_CODE;
                res_nxt.cur_col  = col_out(ccol_dec);
              end
            end
            OP_PRINT, OP_TAB: begin
              cell_we          = 1'b1;
              ram_wdata        = glyph_r;
              res_nxt.kind     = KIND_CELL;
              res_nxt.cell_col = col_out(ccol_r);
              res_nxt.cell_row = row_out(crow_r);
              res_nxt.glyph    = glyph_r;
              res_nxt.last     = !scroll && !more;
              tab_left_nxt     = tab_left_r - 1'b1;
              res_cnt_nxt      = res_after;
              more_nxt         = more;
              if (!wrap) begin
                ccol_nxt        = ccol_ext[COL_W-1:0];
                phase_nxt       = phase_inc;
                res_nxt.cur_col = col_out(ccol_ext[COL_W-1:0]);
                res_nxt.cur_row = row_out(crow_r);
              end else if (!bottom) begin
                ccol_nxt        = '0;
                crow_nxt        = crow_ext[ROW_W-1:0];
                phase_nxt       = '0;
                res_nxt.cur_row = row_out(crow_ext[ROW_W-1:0]);
              end else begin
                ccol_nxt        = '0;
                crow_nxt        = rows_last;
                top_nxt         = top_inc;
                phase_nxt       = '0;
                blank_row_nxt   = top_r;
                blank_col_nxt   = '0;
                res_nxt.cur_row = row_out(rows_last);
              end
              if (scroll) begin
                state_nxt = ST_SCROLL;
              end else if (more) begin
                state_nxt = ST_EXEC;
              end
            end
            default: begin
              res_load = 1'b0;
            end
          endcase
        end
      end
      ST_SCROLL: begin
        if (out_free) begin
          res_load        = 1'b1;
          res_nxt.kind    = KIND_SCROLL;
          res_nxt.cur_col = col_out(ccol_r);
          res_nxt.cur_row = row_out(crow_r);
          res_nxt.last    = !more_r;
          state_nxt       = ST_BLANK;
        end
      end
      ST_BLANK: begin
        cell_we       = 1'b1;
        addr_row      = blank_row_r;
        addr_col      = blank_col_r;
        blank_col_nxt = blank_ext[COL_W-1:0];
        if (blank_ext >= eff_cols) begin
          state_nxt = more_r ? ST_EXEC : ST_IDLE;
        end
      end
    endcase

    if (clr_busy_r) begin
      clr_addr_nxt = clr_addr_r + 1'b1;
      if (clr_addr_r == RAM_AW'(DEPTH - 1)) begin
        clr_busy_nxt = 1'b0;
      end
    end

    if (clear_req) begin
      state_nxt    = ST_IDLE;
      ccol_nxt     = '0;
      crow_nxt     = '0;
      top_nxt      = '0;
      phase_nxt    = '0;
      more_nxt     = 1'b0;
      clr_busy_nxt = 1'b1;
      clr_addr_nxt = '0;
    end

    out_valid_nxt = res_load ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);
  end

  assign addr_full = {addr_row, addr_col};
  assign ram_we    = clr_busy_r || cell_we;
  assign ram_addr  = clr_busy_r ? clr_addr_r : addr_full[RAM_AW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ccol_r      <= '0;
      crow_r      <= '0;
      top_r       <= '0;
      phase_r     <= '0;
      more_r      <= 1'b0;
      clr_busy_r  <= 1'b1;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
      wv_q_r      <= 1'b0;
      wv_q2_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ccol_r      <= ccol_nxt;
      crow_r      <= crow_nxt;
      top_r       <= top_nxt;
      phase_r     <= phase_nxt;
      more_r      <= more_nxt;
      clr_busy_r  <= clr_busy_nxt;
      clr_addr_r  <= clr_addr_nxt;
      out_valid_r <= out_valid_nxt;
      wv_q_r      <= ram_we;
      wv_q2_r     <= wv_q_r;
    end
  end

  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    glyph_r     <= glyph_nxt;
    tab_left_r  <= tab_left_nxt;
    res_cnt_r   <= res_cnt_nxt;
    blank_col_r <= blank_col_nxt;
    blank_row_r <= blank_row_nxt;
    wa_q_r      <= ram_addr;
    wd_q_r      <= ram_wdata;
    wd_q2_r     <= wd_q_r;
    if (res_load) begin
      out_res_r <= res_nxt;
    end
  end

  tcce_ram #(
    .WIDTH (CODE_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk     (clk),
    .we      (ram_we),
    .wr_addr (ram_addr),
    .wr_data (ram_wdata),
    .rd_addr (wa_q_r),
    .rd_data (ram_rdata)
  );

  assign clear_busy = clr_busy_r;
  assign out_tvalid = out_valid_r;
  assign out_res    = out_res_r;

  a_clear_blocks_work: assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy_r |-> (!pop && !res_load))
    else $error("item handled during the clearing pass");

  a_no_result_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    res_load |-> (!out_valid_r || out_tready))
    else $error("result register overwritten before its transfer");

  a_cursor_in_view: assert property (@(posedge clk) disable iff (!rst_n)
    ({1'b0, ccol_r} < eff_cols) && ({1'b0, crow_r} < eff_rows) &&
    ({1'b0, top_r} < eff_rows))
    else $error("cursor or top row outside the rows and columns in use");

  a_store_readback: assert property (@(posedge clk) disable iff (!rst_n)
    wv_q2_r |-> (ram_rdata == wd_q2_r))
    else $error("character store did not hold the written code");

endmodule

// ----- dv/tb_text_console_cursor_engine_core.sv -----
module tb_text_console_cursor_engine_core
  import tcce_pkg::*;
();

  localparam int CYCLE_LIMIT = 800000;
  localparam int SETTLE_CYCLES = 300;
  localparam int HOLD_CYCLES = 400;
  localparam int PHASE_COUNT = 7;
  localparam int CODES_PER_PHASE = 33;
  localparam int PRESSURE_PHASE = 1;
  localparam int STEADY_PHASE = 4;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

  typedef enum logic {
    ROW_CODE,
    ROW_CFG
  } row_op_t;

  typedef struct packed {
    row_op_t               op;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] value;
    logic                  typed;
    result_t               want;
  } script_row_t;

  localparam result_t NO_WANT = '0;

  localparam script_row_t SCRIPT [26] = '{
    '{ROW_CODE, REG_COLS, 8'h41, 1'b1, '{KIND_CELL, 7'd0, 6'd0, 8'h41, 7'd1, 6'd0, 1'b1}},
    '{ROW_CODE, REG_COLS, 8'h00, 1'b1, '{KIND_CELL, 7'd1, 6'd0, 8'h00, 7'd2, 6'd0, 1'b1}},
    '{ROW_CODE, REG_COLS, 8'hFF, 1'b1, '{KIND_CELL, 7'd2, 6'd0, 8'hFF, 7'd3, 6'd0, 1'b1}},
    '{ROW_CODE, REG_COLS, CODE_CR, 1'b1, '{KIND_MOVE, 7'd0, 6'd0, 8'h00, 7'd0, 6'd0, 1'b1}},
    '{ROW_CODE, REG_COLS, CODE_BS, 1'b1, '{KIND_MOVE, 7'd0, 6'd0, 8'h00, 7'd0, 6'd0, 1'b1}},
    '{ROW_CODE, REG_COLS, CODE_TAB, 1'b0, NO_WANT},
    '{ROW_CODE, REG_COLS, CODE_BS, 1'b1, '{KIND_CELL, 7'd7, 6'd0, SPACE_CODE, 7'd7, 6'd0, 1'b1}},
    '{ROW_CODE, REG_COLS, CODE_NL, 1'b1, '{KIND_MOVE, 7'd0, 6'd0, 8'h00, 7'd0, 6'd1, 1'b1}},
    '{ROW_CODE, REG_COLS, 8'h7F, 1'b0, NO_WANT},
    '{ROW_CODE, REG_COLS, 8'h80, 1'b0, NO_WANT},
    '{ROW_CODE, REG_COLS, CODE_TAB, 1'b0, NO_WANT},
    '{ROW_CFG, REG_COLS, 8'd3, 1'b0, NO_WANT},
    '{ROW_CFG, REG_ROWS, 8'd2, 1'b0, NO_WANT},
    '{ROW_CODE, REG_COLS, 8'h78, 1'b1, '{KIND_CELL, 7'd0, 6'd0, 8'h78, 7'd1, 6'd0, 1'b1}},
    '{ROW_CODE, REG_COLS, 8'h79, 1'b0, NO_WANT},
    '{ROW_CODE, REG_COLS, 8'h7A, 1'b1, '{KIND_CELL, 7'd2, 6'd0, 8'h7A, 7'd0, 6'd1, 1'b1}},
    '{ROW_CODE, REG_COLS, CODE_NL, 1'b1, '{KIND_SCROLL, 7'd0, 6'd0, 8'h00, 7'd0, 6'd1, 1'b1}},
    '{ROW_CODE, REG_COLS, 8'h55, 1'b0, NO_WANT},
    '{ROW_CODE, REG_COLS, 8'hAA, 1'b0, NO_WANT},
    '{ROW_CODE, REG_COLS, 8'h33, 1'b0, NO_WANT},
    '{ROW_CODE, REG_COLS, CODE_TAB, 1'b0, NO_WANT},
    '{ROW_CODE, REG_COLS, CODE_BS, 1'b0, NO_WANT},
    '{ROW_CODE, REG_COLS, CODE_BS, 1'b0, NO_WANT},
    '{ROW_CFG, REG_SPARE_A, 8'hFF, 1'b0, NO_WANT},
    '{ROW_CFG, REG_SPARE_B, 8'h00, 1'b0, NO_WANT},
    '{ROW_CODE, REG_COLS, CODE_CR, 1'b0, NO_WANT}
  };

  localparam logic [CFG_DATA_W-1:0] PHASE_COLS [PHASE_COUNT] =
    '{8'd1, 8'd128, 8'd0, 8'd255, 8'd9, 8'd16, 8'd7};
  localparam logic [CFG_DATA_W-1:0] PHASE_ROWS [PHASE_COUNT] =
    '{8'd1, 8'd64, 8'd5, 8'd255, 8'd3, 8'd0, 8'd4};

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [CODE_W-1:0]     in_tdata;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [KIND_W-1:0]     out_tuser;
  logic                  out_tlast;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  int unsigned cols_reg;
  int unsigned rows_reg;
  int unsigned cur_col;
  int unsigned cur_row;
  result_t     step_results [$];
  result_t     pending_results [$];

  int  fail_count;
  int  cycle_count;
  bit  idle_on;
  bit  stall_request;
  bit  codes_since_cfg;

  text_console_cursor_engine_core u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic int unsigned used_cols();
    if (cols_reg == 0) return 1;
    if (cols_reg > MAX_COLS_DEF) return MAX_COLS_DEF;
    return cols_reg;
  endfunction

  function automatic int unsigned used_rows();
    if (rows_reg == 0) return 1;
    if (rows_reg > MAX_ROWS_DEF) return MAX_ROWS_DEF;
    return rows_reg;
  endfunction

  function automatic void log_result(kind_t k, int unsigned col, int unsigned row,
                                     logic [CODE_W-1:0] g);
    result_t r;
    if (step_results.size() >= RESULT_LIMIT) return;
    r.kind     = k;
    r.cell_col = col[COL_OUT_W-1:0];
    r.cell_row = row[ROW_OUT_W-1:0];
    r.glyph    = g;
    r.cur_col  = cur_col[COL_OUT_W-1:0];
    r.cur_row  = cur_row[ROW_OUT_W-1:0];
    r.last     = 1'b0;
    step_results.push_back(r);
  endfunction

  // Returns 1 when the move runs off the bottom row and the view scrolls.
  function automatic bit advance_line();
    cur_col = 0;
    cur_row++;
    if (cur_row >= used_rows()) begin
      cur_row = used_rows() - 1;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void place_glyph(logic [CODE_W-1:0] g);
    int unsigned col;
    int unsigned row;
    bit          scrolled;
    col = cur_col;
    row = cur_row;
    scrolled = 1'b0;
    cur_col++;
    if (cur_col >= used_cols()) scrolled = advance_line();
    log_result(KIND_CELL, col, row, g);
    if (scrolled) log_result(KIND_SCROLL, 0, 0, '0);
  endfunction

  function automatic void track_code(logic [CODE_W-1:0] code);
    int unsigned spaces;
    step_results.delete();
    case (code)
      CODE_NL: begin
        if (advance_line()) log_result(KIND_SCROLL, 0, 0, '0);
        else log_result(KIND_MOVE, 0, 0, '0);
      end
      CODE_CR: begin
        cur_col = 0;
        log_result(KIND_MOVE, 0, 0, '0);
      end
      CODE_TAB: begin
        // A tab stops early when the next space might not fit in the result budget.
        spaces = TAB_WIDTH_DEF - (cur_col % TAB_WIDTH_DEF);
        for (int i = 0; i < spaces; i++) begin
          if (RESULT_LIMIT - step_results.size() < 2) break;
          place_glyph(SPACE_CODE);
        end
        if (step_results.size() == 0) log_result(KIND_MOVE, 0, 0, '0);
      end
      CODE_BS: begin
        if (cur_col == 0) begin
          log_result(KIND_MOVE, 0, 0, '0);
        end else begin
          cur_col--;
          log_result(KIND_CELL, cur_col, cur_row, SPACE_CODE);
        end
      end
      default: place_glyph(code);
    endcase
    step_results[$].last = 1'b1;
  endfunction

  function automatic logic [CODE_W-1:0] pick_code();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 12) return CODE_NL;
    if (r < 18) return CODE_CR;
    if (r < 28) return CODE_TAB;
    if (r < 40) return CODE_BS;
    return CODE_W'($urandom_range(255));
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch on %s: got %0d, want %0d, cycle %0d", what, got, want, cycle_count);
    fail_count++;
  endtask

  task automatic send_code(input logic [CODE_W-1:0] code, input logic typed,
                           input result_t want);
    while (idle_on && $urandom_range(99) < 27) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= code;
    do @(posedge clk); while (!in_tready);
    track_code(code);
    if (typed) pending_results.push_back(want);
    else foreach (step_results[i]) pending_results.push_back(step_results[i]);
    codes_since_cfg = 1'b1;
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    if (codes_since_cfg) begin
      in_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clk);
      // A scroll may still be blanking its row after the last result left.
      repeat (SETTLE_CYCLES) @(posedge clk);
      codes_since_cfg = 1'b0;
    end
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_COLS) begin
      cols_reg = value;
      cur_col = 0;
      cur_row = 0;
    end else if (idx == REG_ROWS) begin
      rows_reg = value[ROWS_REG_W-1:0];
      cur_col = 0;
      cur_row = 0;
    end
    @(posedge clk);
  endtask

  initial begin
    int unsigned hold_left;
    hold_left = 0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_request) begin
        stall_request = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (!idle_on) begin
        out_tready <= 1'b1;
      end else begin
        out_tready <= ($urandom_range(99) >= 27);
      end
    end
  end

  always @(posedge clk) begin : check_results
    result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result kind", out_tuser, -1);
      end else begin
        want = pending_results.pop_front();
        if (out_tuser !== want.kind) report_mismatch("kind", out_tuser, want.kind);
        if (out_tdata[6:0] !== want.cell_col)
          report_mismatch("cell_col", out_tdata[6:0], want.cell_col);
        if (out_tdata[12:7] !== want.cell_row)
          report_mismatch("cell_row", out_tdata[12:7], want.cell_row);
        if (out_tdata[20:13] !== want.glyph)
          report_mismatch("glyph", out_tdata[20:13], want.glyph);
        if (out_tdata[27:21] !== want.cur_col)
          report_mismatch("cursor_col_out", out_tdata[27:21], want.cur_col);
        if (out_tdata[33:28] !== want.cur_row)
          report_mismatch("cursor_row_out", out_tdata[33:28], want.cur_row);
        if (out_tdata[39:34] !== '0) report_mismatch("zero fill", out_tdata[39:34], 0);
        if (out_tlast !== want.last) report_mismatch("last", out_tlast, want.last);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("text_console_cursor_engine_core verification failed");
      $finish;
    end
  end

  initial begin
    fail_count      = 0;
    cycle_count     = 0;
    idle_on         = 1'b1;
    stall_request   = 1'b0;
    codes_since_cfg = 1'b0;
    cols_reg        = COLS_RESET;
    rows_reg        = ROWS_RESET;
    cur_col         = 0;
    cur_row         = 0;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= REG_COLS;
    cfg_wdata <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (SCRIPT[k]) begin
      if (SCRIPT[k].op == ROW_CFG) cfg_write(SCRIPT[k].idx, SCRIPT[k].value);
      else send_code(SCRIPT[k].value, SCRIPT[k].typed, SCRIPT[k].want);
    end

    for (int p = 0; p < PHASE_COUNT; p++) begin
      cfg_write(REG_COLS, PHASE_COLS[p]);
      cfg_write(REG_ROWS, PHASE_ROWS[p]);
      idle_on = (p != STEADY_PHASE);
      for (int i = 0; i < CODES_PER_PHASE; i++) begin
        // The receiver holds off once the clearing pass is over and codes flow.
        if (p == PRESSURE_PHASE && i == 1) stall_request = 1'b1;
        send_code(pick_code(), 1'b0, NO_WANT);
      end
    end

    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("text_console_cursor_engine_core verification clean");
    end else begin
      $display("text_console_cursor_engine_core verification failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/tcce_pkg.sv
rtl/tcce_ram.sv
rtl/tcce_front.sv
rtl/tcce_queue.sv
rtl/tcce_back.sv
rtl/text_console_cursor_engine_core.sv
dv/tb_text_console_cursor_engine_core.sv
